### rtl/rrp_pkg.sv
// Package for the RISC-V relocation patcher: relocation type codes, status
// codes, transaction structs and the immediate scatter functions.
// No dependencies.
package rrp_pkg;

    // Relocation type codes, standard RISC-V ELF numbering
    localparam logic [5:0] RELOC_NONE         = 6'd0;
    localparam logic [5:0] RELOC_32           = 6'd1;
    localparam logic [5:0] RELOC_BRANCH       = 6'd16;
    localparam logic [5:0] RELOC_JAL          = 6'd17;
    localparam logic [5:0] RELOC_CALL_PLT     = 6'd19;
    localparam logic [5:0] RELOC_PCREL_HI20   = 6'd23;
    localparam logic [5:0] RELOC_PCREL_LO12_I = 6'd24;
    localparam logic [5:0] RELOC_PCREL_LO12_S = 6'd25;
    localparam logic [5:0] RELOC_HI20         = 6'd26;
    localparam logic [5:0] RELOC_LO12_I       = 6'd27;
    localparam logic [5:0] RELOC_LO12_S       = 6'd28;

    // Rounding bias for upper-20 immediates
    localparam logic [31:0] ROUND_HALF = 32'h0000_0800;

    typedef enum logic [1:0] {
        ST_APPLIED     = 2'd0,
        ST_SKIPPED     = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } t_status;

    typedef struct packed {
        logic [5:0]  command;
        logic [31:0] insn_word;
        logic [31:0] following_word;
        logic [31:0] symbol_value;
        logic [31:0] addend;
        logic [31:0] place;
        logic        symbol_is_function;
    } t_rrp_req;

    typedef struct packed {
        logic [31:0] patched_word;
        logic [31:0] patched_following;
        logic        write_first;
        logic        write_second;
        t_status     status;
    } t_rrp_rsp;

    // U-type: upper 20 bits rounded, keep rd and opcode
    function automatic logic [31:0] put_upper(logic [31:0] w, logic [31:0] v);
        logic [31:0] r;
        r = v + ROUND_HALF;
        return {r[31:12], w[11:0]};
    endfunction

    // I-type: imm[11:0] in bits 31:20
    function automatic logic [31:0] put_itype(logic [31:0] w, logic [31:0] v);
        return {v[11:0], w[19:0]};
    endfunction

    // S-type: imm[11:5] in 31:25, imm[4:0] in 11:7
    function automatic logic [31:0] put_stype(logic [31:0] w, logic [31:0] v);
        return {v[11:5], w[24:12], v[4:0], w[6:0]};
    endfunction

    // B-type: imm[12|10:5] in 31:25, imm[4:1|11] in 11:7
    function automatic logic [31:0] put_btype(logic [31:0] w, logic [31:0] v);
        return {v[12], v[10:5], w[24:12], v[4:1], v[11], w[6:0]};
    endfunction

    // J-type: imm[20|10:1|11|19:12] in 31:12
    function automatic logic [31:0] put_jtype(logic [31:0] w, logic [31:0] v);
        return {v[20], v[10:1], v[11], v[19:12], w[11:0]};
    endfunction

endpackage

### rtl/rrp_stream_if.sv
// Valid/ready channel interfaces for relocation requests and patch results.
// Depends on nothing but plain logic types.
interface rrp_req_if;
    logic        valid;
    logic        ready;
    logic [5:0]  command;
    logic [31:0] insn_word;
    logic [31:0] following_word;
    logic [31:0] symbol_value;
    logic [31:0] addend;
    logic [31:0] place;
    logic        symbol_is_function;

    modport source (
        output valid, command, insn_word, following_word, symbol_value, addend,
               place, symbol_is_function,
        input  ready
    );
    modport sink (
        input  valid, command, insn_word, following_word, symbol_value, addend,
               place, symbol_is_function,
        output ready
    );
endinterface

interface rrp_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] patched_word;
    logic [31:0] patched_following;
    logic        write_first;
    logic        write_second;
    logic [1:0]  status;

    modport source (
        output valid, patched_word, patched_following, write_first, write_second,
               status,
        input  ready
    );
    modport sink (
        input  valid, patched_word, patched_following, write_first, write_second,
               status,
        output ready
    );
endinterface

### rtl/rrp_patch_unit.sv
// Combinational relocation apply: address arithmetic and immediate scatter.
// Depends on rrp_pkg.
module rrp_patch_unit (
    input  rrp_pkg::t_rrp_req i_req,
    output rrp_pkg::t_rrp_rsp o_rsp
);
    import rrp_pkg::*;

    logic [31:0] sa;
    logic [31:0] rel;
    logic [31:0] lo_rel;

    // S+A, S+A-P and S-P, all wrapping
    assign sa     = i_req.symbol_value + i_req.addend;
    assign rel    = sa - i_req.place;
    assign lo_rel = i_req.symbol_value - i_req.place;

    // Select the patch by relocation type
    always_comb begin
        o_rsp.patched_word      = i_req.insn_word;
        o_rsp.patched_following = i_req.following_word;
        o_rsp.write_first       = 1'b0;
        o_rsp.write_second      = 1'b0;
        o_rsp.status            = ST_APPLIED;
        unique case (i_req.command)
            RELOC_NONE: begin
                o_rsp.status = ST_SKIPPED;
            end
            RELOC_32: begin
                o_rsp.patched_word = sa;
                o_rsp.write_first  = 1'b1;
            end
            RELOC_BRANCH: begin
                if (i_req.symbol_is_function) begin
                    o_rsp.patched_word = put_btype(i_req.insn_word, rel);
                    o_rsp.write_first  = 1'b1;
                end else begin
                    o_rsp.status = ST_SKIPPED;
                end
            end
            RELOC_JAL: begin
                if (i_req.symbol_is_function) begin
                    o_rsp.patched_word = put_jtype(i_req.insn_word, rel);
                    o_rsp.write_first  = 1'b1;
                end else begin
                    o_rsp.status = ST_SKIPPED;
                end
            end
            RELOC_CALL_PLT: begin
                // auipc takes the rounded upper part, jalr the low 12 bits
                if (i_req.symbol_is_function) begin
                    o_rsp.patched_word      = put_upper(i_req.insn_word, rel);
                    o_rsp.patched_following = put_itype(i_req.following_word, rel);
                    o_rsp.write_first       = 1'b1;
                    o_rsp.write_second      = 1'b1;
                end else begin
                    o_rsp.status = ST_SKIPPED;
                end
            end
            RELOC_PCREL_HI20: begin
                o_rsp.patched_word = put_upper(i_req.insn_word, rel);
                o_rsp.write_first  = 1'b1;
            end
            RELOC_PCREL_LO12_I: begin
                o_rsp.patched_word = put_itype(i_req.insn_word, lo_rel);
                o_rsp.write_first  = 1'b1;
            end
            RELOC_PCREL_LO12_S: begin
                o_rsp.patched_word = put_stype(i_req.insn_word, lo_rel);
                o_rsp.write_first  = 1'b1;
            end
            RELOC_HI20: begin
                o_rsp.patched_word = put_upper(i_req.insn_word, sa);
                o_rsp.write_first  = 1'b1;
            end
            RELOC_LO12_I: begin
                o_rsp.patched_word = put_itype(i_req.insn_word, sa);
                o_rsp.write_first  = 1'b1;
            end
            RELOC_LO12_S: begin
                o_rsp.patched_word = put_stype(i_req.insn_word, sa);
                o_rsp.write_first  = 1'b1;
            end
            default: begin
                o_rsp.status = ST_UNSUPPORTED;
            end
        endcase
    end

endmodule

### rtl/riscv_relocation_patcher_core.sv
// Pipeline: an accepted request transaction is captured in the input register, passes
// through the patch unit and is then captured in the result register, which presents
// it until the result is taken (input register, then result register).
// Throughput: one relocation per cycle; the adder and scatter logic sit
// between the two registers, and a stalled output holds both stages.
// Reset (synchronous, active low) clears both valid flags; payloads are not reset.
// Depends on rrp_pkg, rrp_stream_if and rrp_patch_unit.
module riscv_relocation_patcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrp_req_if.sink     i_in,
    rrp_rsp_if.source   o_out
);
    import rrp_pkg::*;

    t_rrp_req r_req;
    t_rrp_req n_req;
    logic     r_req_vld;
    logic     n_req_vld;
    t_rrp_rsp r_rsp;
    t_rrp_rsp n_rsp;
    logic     r_rsp_vld;
    logic     n_rsp_vld;
    t_rrp_rsp patch_rsp;
    logic     adv_out;
    logic     take_in;

    // Advance the result stage when it is empty or being drained
    assign adv_out    = !r_rsp_vld || o_out.ready;
    assign i_in.ready = !r_req_vld || adv_out;
    assign take_in    = i_in.ready;

    rrp_patch_unit u_patch (
        .i_req (r_req),
        .o_rsp (patch_rsp)
    );

    // Next state of both stages
    always_comb begin
        n_req     = r_req;
        n_req_vld = r_req_vld;
        n_rsp     = r_rsp;
        n_rsp_vld = r_rsp_vld;
        if (take_in) begin
            n_req_vld                  = i_in.valid;
            n_req.command              = i_in.command;
            n_req.insn_word            = i_in.insn_word;
            n_req.following_word       = i_in.following_word;
            n_req.symbol_value         = i_in.symbol_value;
            n_req.addend               = i_in.addend;
            n_req.place                = i_in.place;
            n_req.symbol_is_function   = i_in.symbol_is_function;
        end
        if (adv_out) begin
            n_rsp_vld = r_req_vld;
            n_rsp     = patch_rsp;
        end
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_req_vld <= n_req_vld;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

    // Drive the result channel
    assign o_out.valid             = r_rsp_vld;
    assign o_out.patched_word      = r_rsp.patched_word;
    assign o_out.patched_following = r_rsp.patched_following;
    assign o_out.write_first       = r_rsp.write_first;
    assign o_out.write_second      = r_rsp.write_second;
    assign o_out.status            = r_rsp.status;

endmodule
